>>> rtl/tbhs_pkg.sv
// Package for the tape block header scanner: result record type, kind codes and
// the fixed constants of the tape block format. No dependencies.

package tbhs_pkg;

  // Default widths and depths handed to the top level.
  localparam int OFFSET_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Fixed format constants.
  localparam int NAME_CHARS      = 10;
  localparam int HEADER_BYTES    = 17;
  localparam int OUT_OFFSET_BITS = 24;

  localparam logic [7:0]  HEADER_FLAG   = 8'h00;
  localparam logic [7:0]  SPACE_CHAR    = 8'h20;
  localparam logic [15:0] MIN_LENGTH    = 16'd2;
  localparam logic [4:0]  DECL_LO_INDEX = 5'd11;
  localparam logic [4:0]  DECL_HI_INDEX = 5'd12;
  localparam logic [4:0]  LAST_HDR_INDEX = 5'(HEADER_BYTES - 1);
  localparam logic [23:0] OFFSET_MAX    = 24'hFFFFFF;

  // Result kinds.
  localparam logic [1:0] KIND_BLOCK     = 2'd0;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;

  // One result as it travels from the front part to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] offset;
    logic [15:0] data_length;
    logic [7:0]  flag;
    logic        hdr;
    logic [7:0]  file_type;
    logic [15:0] declared;
    logic [63:0] name_first;
    logic [15:0] name_last;
    logic [3:0]  name_len;
  } rec_t;

endpackage

>>> rtl/tbhs_front.sv
// Front part of the tape block header scanner: walks the block structure one
// byte per transfer and pushes one result record per block, once its flag byte
// or header is read, and one per end mark. Depends on tbhs_pkg.

module tbhs_front #(
  parameter int OFFSET_BITS = tbhs_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  output logic           push,
  output tbhs_pkg::rec_t push_rec
);

  localparam logic [2:0] PH_LEN_LO = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_FLAG   = 3'd2;
  localparam logic [2:0] PH_HEADER = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  localparam int EXT_W = (OFFSET_BITS > tbhs_pkg::OUT_OFFSET_BITS) ?
                         OFFSET_BITS : tbhs_pkg::OUT_OFFSET_BITS;

  logic [2:0]             phase;
  logic [7:0]             len_lo;
  logic [15:0]            dlen;
  logic [15:0]            remaining;
  logic [4:0]             hidx;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] bstart;
  logic [7:0]             ctype;
  logic [7:0]             name [tbhs_pkg::NAME_CHARS];
  logic [15:0]            cdecl;
  logic [3:0]             nlen;
  logic                   err;

  logic [15:0]            len_full;
  logic [EXT_W-1:0]       start_ext;
  logic [23:0]            start_sat;
  logic                   is_header;

  assign len_full  = {data_byte, len_lo};
  assign start_ext = EXT_W'(bstart);
  assign start_sat = (start_ext > EXT_W'(tbhs_pkg::OFFSET_MAX)) ?
                     tbhs_pkg::OFFSET_MAX : start_ext[23:0];
  assign is_header = (data_byte == tbhs_pkg::HEADER_FLAG) &&
                     (dlen >= 16'(tbhs_pkg::HEADER_BYTES));

  always_comb begin
    push               = 1'b0;
    push_rec           = '0;
    push_rec.offset    = start_sat;
    push_rec.data_length = dlen;
    push_rec.flag      = data_byte;
    push_rec.file_type = ctype;
    push_rec.declared  = cdecl;
    push_rec.name_first = {name[0], name[1], name[2], name[3],
                           name[4], name[5], name[6], name[7]};
    push_rec.name_last = {name[8], name[9]};
    push_rec.name_len  = nlen;
    if (fire) begin
      if (end_of_file) begin
        push = 1'b1;
        push_rec.kind = (err || phase == PH_FLAG || phase == PH_HEADER) ?
                        tbhs_pkg::KIND_MALFORMED : tbhs_pkg::KIND_END;
      end else if (phase == PH_FLAG && !is_header) begin
        push = 1'b1;
        push_rec.kind = tbhs_pkg::KIND_BLOCK;
      end else if (phase == PH_HEADER && hidx == tbhs_pkg::LAST_HDR_INDEX) begin
        push = 1'b1;
        push_rec.kind = tbhs_pkg::KIND_BLOCK;
        push_rec.hdr  = 1'b1;
        push_rec.flag = tbhs_pkg::HEADER_FLAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEN_LO;
      len_lo    <= '0;
      dlen      <= '0;
      remaining <= '0;
      hidx      <= '0;
      pos       <= '0;
      bstart    <= '0;
      ctype     <= '0;
      cdecl     <= '0;
      nlen      <= '0;
      err       <= 1'b0;
    end else if (fire) begin
      if (end_of_file) begin
        phase     <= PH_LEN_LO;
        len_lo    <= '0;
        dlen      <= '0;
        remaining <= '0;
        hidx      <= '0;
        pos       <= '0;
        bstart    <= '0;
        ctype     <= '0;
        cdecl     <= '0;
        nlen      <= '0;
        err       <= 1'b0;
      end else begin
        if (phase == PH_LEN_LO) begin
          bstart <= pos;
        end
        if (pos != '1) begin
          pos <= pos + 1'b1;
        end
        case (phase)
          PH_LEN_LO: begin
            len_lo <= data_byte;
            phase  <= PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (len_full < tbhs_pkg::MIN_LENGTH) begin
              err   <= 1'b1;
              phase <= PH_ERROR;
            end else begin
              dlen  <= len_full - tbhs_pkg::MIN_LENGTH;
              phase <= PH_FLAG;
            end
          end
          PH_FLAG: begin
            if (is_header) begin
              hidx  <= '0;
              nlen  <= '0;
              phase <= PH_HEADER;
            end else begin
              remaining <= dlen + 16'd1;
              phase     <= PH_SKIP;
            end
          end
          PH_HEADER: begin
            if (hidx == 5'd0) begin
              ctype <= data_byte;
            end else if (hidx <= 5'(tbhs_pkg::NAME_CHARS)) begin
              // Trimmed length is the position of the last non-space seen.
              if (data_byte != tbhs_pkg::SPACE_CHAR) begin
                nlen <= hidx[3:0];
              end
            end else if (hidx == tbhs_pkg::DECL_LO_INDEX) begin
              cdecl[7:0] <= data_byte;
            end else if (hidx == tbhs_pkg::DECL_HI_INDEX) begin
              cdecl[15:8] <= data_byte;
            end
            if (hidx == tbhs_pkg::LAST_HDR_INDEX) begin
              hidx      <= '0;
              remaining <= dlen - 16'(tbhs_pkg::HEADER_BYTES - 1);
              phase     <= PH_SKIP;
            end else begin
              hidx <= hidx + 5'd1;
            end
          end
          PH_SKIP: begin
            if (remaining != '0) begin
              remaining <= remaining - 16'd1;
            end
            if (remaining <= 16'd1) begin
              phase <= PH_LEN_LO;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Name characters sit in the header at byte positions one to ten.
  always_ff @(posedge clk) begin
    for (int i = 0; i < tbhs_pkg::NAME_CHARS; i++) begin
      if (fire && !end_of_file && phase == PH_HEADER && hidx == 5'(i + 1)) begin
        name[i] <= data_byte;
      end
    end
  end

endmodule

>>> rtl/tbhs_queue.sv
// Short record queue between the front and back parts of the scanner.
// Depends on tbhs_pkg for the record type.

module tbhs_queue #(
  parameter int DEPTH = tbhs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tbhs_pkg::rec_t push_rec,
  input  logic           pop,
  output tbhs_pkg::rec_t head,
  output logic           not_empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tbhs_pkg::rec_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tbhs_back.sv
// Back part of the scanner: takes records from the queue into the output
// register and clears the fields that carry no meaning for each kind.
// Depends on tbhs_pkg.

module tbhs_back (
  input  logic           clk,
  input  logic           rst,
  input  tbhs_pkg::rec_t head,
  input  logic           not_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     result_kind,
  output logic [23:0]    block_offset,
  output logic [15:0]    data_length,
  output logic [7:0]     flag_value,
  output logic           has_header,
  output logic [7:0]     file_type,
  output logic [15:0]    declared_length,
  output logic [63:0]    name_first_eight,
  output logic [15:0]    name_last_two,
  output logic [3:0]     name_length,
  output logic           is_last
);

  logic is_block;
  logic is_hdr;

  assign pop      = not_empty && (!out_valid || out_ready);
  assign is_block = (head.kind == tbhs_pkg::KIND_BLOCK);
  assign is_hdr   = is_block && head.hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_kind      <= head.kind;
      block_offset     <= is_block ? head.offset : '0;
      data_length      <= is_block ? head.data_length : '0;
      flag_value       <= is_block ? head.flag : '0;
      has_header       <= is_hdr;
      file_type        <= is_hdr ? head.file_type : '0;
      declared_length  <= is_hdr ? head.declared : '0;
      name_first_eight <= is_hdr ? head.name_first : '0;
      name_last_two    <= is_hdr ? head.name_last : '0;
      name_length      <= is_hdr ? head.name_len : '0;
      // Every input item causes at most one result.
      is_last          <= 1'b1;
    end
  end

endmodule

>>> rtl/tape_block_header_scanner.sv
// Tape block header scanner, top level.
// Takes a tape image one byte per input transfer (data_byte), or an end mark
// (end_of_file); reports each block before any too-short length, with header
// fields if a header, then a clean-end or malformed status at stream end.
// Both channels use valid/ready; a transfer happens when both are high.
// Throughput: one input byte per cycle, sustained, as long as results are
// taken. Each byte updates the front part's state; each transfer yields at
// most one result, with is_last always set.
// A result reaches the output through a queue write and then an output
// register load after the input transfer that causes it.
// A queue of QUEUE_DEPTH records parts the front and back parts. When the
// receiver stalls, the output register holds its result and the queue fills;
// in_ready falls only once the queue is full, and rises again as results go.
// Reset (synchronous, active high) returns the scanner to expecting a length
// byte at offset zero and empties the queue and output register. An end of
// file transfer does the same to the scanner state after its status.
// Depends on tbhs_pkg, tbhs_front, tbhs_queue and tbhs_back.

module tape_block_header_scanner #(
  parameter int OFFSET_BITS = tbhs_pkg::OFFSET_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = tbhs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [23:0] block_offset,
  output logic [15:0] data_length,
  output logic [7:0]  flag_value,
  output logic        has_header,
  output logic [7:0]  file_type,
  output logic [15:0] declared_length,
  output logic [63:0] name_first_eight,
  output logic [15:0] name_last_two,
  output logic [3:0]  name_length,
  output logic        is_last
);

  logic           fire;
  logic           push;
  tbhs_pkg::rec_t push_rec;
  tbhs_pkg::rec_t head;
  logic           pop;
  logic           not_empty;
  logic           full;

  assign in_ready = !full;
  assign fire     = in_valid && in_ready;

  tbhs_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .push       (push),
    .push_rec   (push_rec)
  );

  tbhs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .not_empty(not_empty),
    .full     (full)
  );

  tbhs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .not_empty       (not_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .block_offset    (block_offset),
    .data_length     (data_length),
    .flag_value      (flag_value),
    .has_header      (has_header),
    .file_type       (file_type),
    .declared_length (declared_length),
    .name_first_eight(name_first_eight),
    .name_last_two   (name_last_two),
    .name_length     (name_length),
    .is_last         (is_last)
  );

endmodule

>>> rtl/tbhs_checker.sv
// Port-level checker for the tape block header scanner, bound to the top level.
// Depends on tbhs_pkg and tape_block_header_scanner.

module tbhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [23:0] block_offset,
  input logic [15:0] data_length,
  input logic [7:0]  flag_value,
  input logic        has_header,
  input logic [7:0]  file_type,
  input logic [15:0] declared_length,
  input logic [3:0]  name_length,
  input logic        is_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result_kind) && $stable(block_offset) &&
                                $stable(data_length))
    else $error("stalled result changed");

  // Status results carry nothing but their kind and is_last.
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != tbhs_pkg::KIND_BLOCK |->
      block_offset == '0 && data_length == '0 && flag_value == '0 &&
      !has_header && is_last)
    else $error("status result has stray fields");

  // A header record always comes from a long enough block with a zero flag.
  a_header_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_header |->
      result_kind == tbhs_pkg::KIND_BLOCK && flag_value == tbhs_pkg::HEADER_FLAG &&
      data_length >= 16'(tbhs_pkg::HEADER_BYTES) &&
      name_length <= 4'(tbhs_pkg::NAME_CHARS))
    else $error("header record inconsistent");

  a_plain_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_header |->
      file_type == '0 && declared_length == '0 && name_length == '0 &&
      (result_kind == tbhs_pkg::KIND_BLOCK || result_kind == tbhs_pkg::KIND_END ||
       result_kind == tbhs_pkg::KIND_MALFORMED))
    else $error("non-header result has header fields");

endmodule

bind tape_block_header_scanner tbhs_checker u_tbhs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .result_kind    (result_kind),
  .block_offset   (block_offset),
  .data_length    (data_length),
  .flag_value     (flag_value),
  .has_header     (has_header),
  .file_type      (file_type),
  .declared_length(declared_length),
  .name_length    (name_length),
  .is_last        (is_last)
);
